FILE: rtl/imu_static_init_statistics_macros.svh
// ----------------------------------------------------------------------------
// IMU static initialisation statistics: assertion macros
// Shared macros for the concurrent assertions of the block.
// ----------------------------------------------------------------------------
`ifndef IMU_STATIC_INIT_STATISTICS_MACROS_SVH
`define IMU_STATIC_INIT_STATISTICS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMU_SIS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMU_SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/imu_sis_pkg.sv
// ----------------------------------------------------------------------------
// IMU static initialisation statistics: package
// Field widths, beat types, sequencer states and the shared unit interface.
// ----------------------------------------------------------------------------
package imu_sis_pkg;

  localparam int IN_W      = 16;
  localparam int NUM_AXES  = 6;
  localparam int AXIS_W    = 3;
  localparam int MEAN_W    = 32;
  localparam int VAR_W     = 48;
  localparam int CNT_W     = 16;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int UNIT_AW   = 64;
  localparam int UNIT_BW   = 32;

  typedef struct packed {
    logic signed [IN_W-1:0] acc_x;
    logic signed [IN_W-1:0] acc_y;
    logic signed [IN_W-1:0] acc_z;
    logic signed [IN_W-1:0] gyr_x;
    logic signed [IN_W-1:0] gyr_y;
    logic signed [IN_W-1:0] gyr_z;
    logic                   batch_end;
  } in_payload_t;

  typedef struct packed {
    logic [AXIS_W-1:0]        axis;
    logic signed [MEAN_W-1:0] mean_value;
    logic [VAR_W-1:0]         variance_value;
    logic [CNT_W-1:0]         sample_count;
    logic                     init_done;
    logic                     last_axis;
  } out_payload_t;

  typedef enum logic {
    UOP_MUL,
    UOP_DIV
  } unit_op_t;

  typedef struct packed {
    logic               start;
    unit_op_t           op;
    logic [UNIT_AW-1:0] a;
    logic [UNIT_BW-1:0] b;
  } unit_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [UNIT_AW-1:0] result;
  } unit_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NSQ,
    ST_NSQ_W,
    ST_DELTA,
    ST_MNUM,
    ST_MDIV_W,
    ST_MUPD,
    ST_DEV,
    ST_DABS,
    ST_SQ_W,
    ST_VMUL_W,
    ST_ADIV_W,
    ST_BMUL_W,
    ST_BDIV_W,
    ST_COUNT,
    ST_OUT
  } seq_state_t;

endpackage

FILE: rtl/imu_sis_unit.sv
// ----------------------------------------------------------------------------
// IMU static initialisation statistics: shared arithmetic unit
// Shift-add multiplier and restoring divider around one adder, one bit a cycle.
// ----------------------------------------------------------------------------
module imu_sis_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  imu_sis_pkg::unit_cmd_t cmd,
  output imu_sis_pkg::unit_sts_t sts
);
  import imu_sis_pkg::*;

  localparam int CW = $clog2(UNIT_AW);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  unit_op_t           op_r, op_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [UNIT_AW-1:0] acc_r, acc_nxt;
  logic [UNIT_AW-1:0] x_r, x_nxt;
  logic [UNIT_BW-1:0] y_r, y_nxt;
  logic [UNIT_BW-1:0] rem_r, rem_nxt;

  logic [UNIT_BW:0]   shifted;
  logic [UNIT_AW-1:0] add_a, add_b;
  logic               sub;
  logic [UNIT_AW:0]   sum;
  logic               qbit;
  logic [CW-1:0]      last_step;

  assign shifted   = {rem_r, x_r[UNIT_AW-1]};
  assign sub       = (op_r == UOP_DIV);
  assign add_a     = sub ? UNIT_AW'(shifted) : acc_r;
  assign add_b     = sub ? UNIT_AW'(y_r) : x_r;
  assign sum       = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + (UNIT_AW+1)'(sub);
  assign qbit      = sum[UNIT_AW];
  assign last_step = (op_r == UOP_MUL) ? CW'(UNIT_BW - 1) : CW'(UNIT_AW - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      unique case (op_r)
        UOP_MUL: begin
          acc_nxt = y_r[0] ? sum[UNIT_AW-1:0] : acc_r;
          x_nxt   = x_r << 1;
          y_nxt   = y_r >> 1;
        end
        UOP_DIV: begin
          rem_nxt = qbit ? sum[UNIT_BW-1:0] : shifted[UNIT_BW-1:0];
          acc_nxt = {acc_r[UNIT_AW-2:0], qbit};
          x_nxt   = x_r << 1;
        end
      endcase
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      x_nxt    = cmd.a;
      y_nxt    = cmd.b;
      rem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy   = busy_r;
  assign sts.done   = done_r;
  assign sts.result = acc_r;

endmodule

FILE: rtl/imu_sis_apb.sv
// ----------------------------------------------------------------------------
// IMU static initialisation statistics: configuration register
// APB-style slave holding the initialisation sample threshold.
// ----------------------------------------------------------------------------
module imu_sis_apb (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [imu_sis_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [imu_sis_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [imu_sis_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic [imu_sis_pkg::CNT_W-1:0]  threshold
);
  import imu_sis_pkg::*;

  localparam int IDX_W = CFG_AW - 2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = '0;
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(10);

  logic [CNT_W-1:0] thr_r, thr_nxt;
  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en && (reg_idx == REG_THRESHOLD)) begin
      thr_nxt = cfg_pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign cfg_prdata = (reg_idx == REG_THRESHOLD) ? CFG_DW'(thr_r) : '0;
  assign threshold  = thr_r;

endmodule

FILE: rtl/imu_static_init_statistics.sv
// ----------------------------------------------------------------------------
// IMU static initialisation statistics
// Running mean and variance per axis of six-axis IMU samples, one shared unit.
// ----------------------------------------------------------------------------
// Usage. Samples enter on the in_ channel (in_valid, in_stall, in_data); a
// beat is taken when in_valid is high and in_stall is low. Results leave on
// the out_ channel in the same way. The threshold is written over the cfg_
// APB-style port; the user must write it only while the block is idle, which the block itself does not enforce.
// Every sample runs through a sequencer that drives one shared unit: a
// shift-add multiplier and a restoring divider. Each axis needs three
// divisions and three multiplications, and in_stall is high throughout
// the processing of a sample. A sample marked batch_end then gives six
// result beats, one per axis, the sixth with last_axis set. Once
// initialisation is done, samples are taken at once and discarded.
// A stalled result beat holds, and no new sample is taken until all six
// beats have gone. Reset clears the statistics, sets the count to one, arms
// the seeding of the means by the next sample and sets the threshold to 10.
// ----------------------------------------------------------------------------
`include "imu_static_init_statistics_macros.svh"

module imu_static_init_statistics #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  imu_sis_pkg::in_payload_t       in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output imu_sis_pkg::out_payload_t      out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [imu_sis_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [imu_sis_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [imu_sis_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import imu_sis_pkg::*;

  localparam int XW    = SAMPLE_BITS;
  localparam int XSW   = XW + 16;
  localparam int EXT_W = (XW > IN_W) ? XW : IN_W;
  localparam int DW    = ((XSW > MEAN_W) ? XSW : MEAN_W) + 1;
  localparam int SW    = DW + 2;
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  function automatic logic signed [XW-1:0] sample_of(input logic [IN_W-1:0] raw);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(raw);
    return ext[XW-1:0];
  endfunction

  function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [SW-1:0] v);
    logic hi, lo;
    hi = !v[SW-1] && (|v[SW-2:MEAN_W-1]);
    lo = v[SW-1] && !(&v[SW-2:MEAN_W-1]);
    if (hi) begin
      return {1'b0, {(MEAN_W-1){1'b1}}};
    end else if (lo) begin
      return {1'b1, {(MEAN_W-1){1'b0}}};
    end
    return v[MEAN_W-1:0];
  endfunction

  seq_state_t               state_r, state_nxt;
  logic [AXIS_W-1:0]        k_r, k_nxt;
  logic signed [XW-1:0]     smp_r [NUM_AXES];
  logic signed [XW-1:0]     smp_nxt [NUM_AXES];
  logic                     batch_end_r, batch_end_nxt;
  logic signed [MEAN_W-1:0] mean_r [NUM_AXES];
  logic signed [MEAN_W-1:0] mean_nxt [NUM_AXES];
  logic [VAR_W-1:0]         var_r [NUM_AXES];
  logic [VAR_W-1:0]         var_nxt [NUM_AXES];
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     first_r, first_nxt;
  logic                     done_r, done_nxt;
  logic signed [DW-1:0]     delta_r, delta_nxt;
  logic [2*CNT_W-1:0]       nsq_r, nsq_nxt;
  logic [VAR_W-1:0]         t_r, t_nxt;
  logic [VAR_W-1:0]         a_r, a_nxt;

  unit_cmd_t                unit_cmd;
  unit_sts_t                unit_sts;
  logic [CNT_W-1:0]         threshold;

  logic signed [XW-1:0]     in_smp [NUM_AXES];
  logic signed [XSW-1:0]    xs_cur;
  logic signed [DW-1:0]     xs_ext, mean_ext, dev_diff;
  logic                     neg;
  logic [DW:0]              num_m;
  logic [SW-1:0]            q_ext;
  logic signed [SW-1:0]     sum_m;
  logic [DW-1:0]            absd;
  logic [UNIT_BW-1:0]       dm;
  logic [VAR_W+1:0]         var_sum;
  logic [CNT_W-1:0]         cnt_inc, nm1;
  logic [CNT_W-2:0]         half_n;
  logic                     in_acc;

  imu_sis_apb u_apb (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .threshold   (threshold)
  );

  imu_sis_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (unit_cmd),
    .sts   (unit_sts)
  );

  assign in_smp[0] = sample_of(in_data.acc_x);
  assign in_smp[1] = sample_of(in_data.acc_y);
  assign in_smp[2] = sample_of(in_data.acc_z);
  assign in_smp[3] = sample_of(in_data.gyr_x);
  assign in_smp[4] = sample_of(in_data.gyr_y);
  assign in_smp[5] = sample_of(in_data.gyr_z);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign xs_cur   = {smp_r[k_r], 16'b0};
  assign xs_ext   = {{(DW-XSW){xs_cur[XSW-1]}}, xs_cur};
  assign mean_ext = {{(DW-MEAN_W){mean_r[k_r][MEAN_W-1]}}, mean_r[k_r]};
  assign dev_diff = xs_ext - mean_ext;
  assign neg      = delta_r[DW-1];
  assign half_n   = count_r[CNT_W-1:1];
  assign nm1      = count_r - 1'b1;
  assign cnt_inc  = (count_r == '1) ? count_r : count_r + 1'b1;

  assign num_m = {1'b0, (neg ? ~delta_r : delta_r)} + (DW+1)'(half_n) + (DW+1)'(neg);
  assign q_ext = {2'b00, unit_sts.result[DW-1:0]};
  assign sum_m = {{(SW-MEAN_W){mean_r[k_r][MEAN_W-1]}}, mean_r[k_r]}
               + (neg ? ~q_ext : q_ext) + SW'(neg);

  assign absd = neg ? -delta_r : delta_r;
  assign dm   = (|absd[DW-1:UNIT_BW]) ? '1 : absd[UNIT_BW-1:0];

  assign var_sum = {2'b00, a_r} + {1'b0, unit_sts.result[VAR_W:0]};

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    smp_nxt       = smp_r;
    batch_end_nxt = batch_end_r;
    mean_nxt      = mean_r;
    var_nxt       = var_r;
    count_nxt     = count_r;
    first_nxt     = first_r;
    done_nxt      = done_r;
    delta_nxt     = delta_r;
    nsq_nxt       = nsq_r;
    t_nxt         = t_r;
    a_nxt         = a_r;
    unit_cmd      = '{start: 1'b0, op: UOP_MUL, a: '0, b: '0};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !done_r) begin
          smp_nxt       = in_smp;
          batch_end_nxt = in_data.batch_end;
          k_nxt         = '0;
          if (first_r) begin
            first_nxt = 1'b0;
            count_nxt = CNT_W'(1);
            for (int i = 0; i < NUM_AXES; i++) begin
              mean_nxt[i] = sat_mean(SW'($signed({in_smp[i], 16'b0})));
            end
          end
          state_nxt = ST_NSQ;
        end
      end
      ST_NSQ: begin
        unit_cmd  = '{start: 1'b1, op: UOP_MUL, a: UNIT_AW'(count_r), b: UNIT_BW'(count_r)};
        state_nxt = ST_NSQ_W;
      end
      ST_NSQ_W: begin
        if (unit_sts.done) begin
          nsq_nxt   = unit_sts.result[2*CNT_W-1:0];
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        delta_nxt = dev_diff;
        state_nxt = ST_MNUM;
      end
      ST_MNUM: begin
        unit_cmd  = '{start: 1'b1, op: UOP_DIV, a: UNIT_AW'(num_m), b: UNIT_BW'(count_r)};
        state_nxt = ST_MDIV_W;
      end
      ST_MDIV_W: begin
        if (unit_sts.done) begin
          state_nxt = ST_MUPD;
        end
      end
      ST_MUPD: begin
        mean_nxt[k_r] = sat_mean(sum_m);
        state_nxt     = ST_DEV;
      end
      ST_DEV: begin
        delta_nxt = dev_diff;
        state_nxt = ST_DABS;
      end
      ST_DABS: begin
        unit_cmd  = '{start: 1'b1, op: UOP_MUL, a: UNIT_AW'(dm), b: dm};
        state_nxt = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (unit_sts.done) begin
          t_nxt     = unit_sts.result[UNIT_AW-1:16];
          unit_cmd  = '{start: 1'b1, op: UOP_MUL, a: UNIT_AW'(var_r[k_r]),
                        b: UNIT_BW'(nm1)};
          state_nxt = ST_VMUL_W;
        end
      end
      ST_VMUL_W: begin
        if (unit_sts.done) begin
          unit_cmd  = '{start: 1'b1, op: UOP_DIV,
                        a: unit_sts.result + UNIT_AW'(half_n), b: UNIT_BW'(count_r)};
          state_nxt = ST_ADIV_W;
        end
      end
      ST_ADIV_W: begin
        if (unit_sts.done) begin
          a_nxt     = unit_sts.result[VAR_W-1:0];
          unit_cmd  = '{start: 1'b1, op: UOP_MUL, a: UNIT_AW'(t_r), b: UNIT_BW'(nm1)};
          state_nxt = ST_BMUL_W;
        end
      end
      ST_BMUL_W: begin
        if (unit_sts.done) begin
          unit_cmd  = '{start: 1'b1, op: UOP_DIV,
                        a: unit_sts.result + UNIT_AW'(nsq_r[2*CNT_W-1:1]), b: nsq_r};
          state_nxt = ST_BDIV_W;
        end
      end
      ST_BDIV_W: begin
        if (unit_sts.done) begin
          var_nxt[k_r] = (|var_sum[VAR_W+1:VAR_W]) ? '1 : var_sum[VAR_W-1:0];
          if (k_r == LAST_AXIS) begin
            k_nxt     = '0;
            state_nxt = ST_COUNT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_DELTA;
          end
        end
      end
      ST_COUNT: begin
        count_nxt = cnt_inc;
        k_nxt     = '0;
        if (batch_end_r) begin
          if (cnt_inc > threshold) begin
            done_nxt = 1'b1;
          end
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (k_r == LAST_AXIS) begin
            k_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      count_r  <= CNT_W'(1);
      first_r  <= 1'b1;
      done_r   <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        mean_r[i] <= '0;
        var_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      count_r  <= count_nxt;
      first_r  <= first_nxt;
      done_r   <= done_nxt;
      mean_r   <= mean_nxt;
      var_r    <= var_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r       <= smp_nxt;
    batch_end_r <= batch_end_nxt;
    delta_r     <= delta_nxt;
    nsq_r       <= nsq_nxt;
    t_r         <= t_nxt;
    a_r         <= a_nxt;
  end

  assign out_valid               = (state_r == ST_OUT);
  assign out_data.axis           = k_r;
  assign out_data.mean_value     = mean_r[k_r];
  assign out_data.variance_value = var_r[k_r];
  assign out_data.sample_count   = count_r;
  assign out_data.init_done      = done_r;
  assign out_data.last_axis      = (k_r == LAST_AXIS);

  `IMU_SIS_ASSERT(a_unit_start_idle, unit_cmd.start, !unit_sts.busy, "unit started while busy")
  `IMU_SIS_ASSERT(a_ready_unit_idle, !in_stall, !unit_sts.busy, "ready while unit busy")
  `IMU_SIS_ASSERT(a_seed_pending, first_r, !done_r && (count_r == CNT_W'(1)), "seed state broken")
  `IMU_SIS_ASSERT_NEXT(a_last_beat, out_valid && !out_stall && out_data.last_axis, !out_valid, "result beat after the sixth")
  `IMU_SIS_ASSERT_NEXT(a_done_discard, in_acc && done_r, !in_stall && !out_valid, "sample processed after done")

endmodule
